// ----- hdl/klv_fd_pkg.sv -----
// Shared types and constants for the KLV frame delineator.
// Used by klv_fd_cfg_regs, klv_fd_parser and klv_frame_delineator.
// No dependencies.
`default_nettype none

package klv_fd_pkg;

	// Parse phase, one-hot
	typedef enum logic [2:0] {
		PH_KEY   = 3'b001,
		PH_LEN   = 3'b010,
		PH_VALUE = 3'b100
	} phase_t;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK         = 2'd0;
	localparam status_t ST_BAD_FORM   = 2'd1;
	localparam status_t ST_OVER_LIMIT = 2'd2;

	// Register indexes on the configuration port
	localparam logic REG_MAX_FRAME = 1'b0;

	localparam logic [31:0] RESET_MAX_FRAME = 32'hFFFF_FFFF;
	localparam logic [31:0] UL_PREFIX_LEN   = 32'd4;
	localparam logic [31:0] KEY_BYTES       = 32'd16;
	localparam logic [31:0] SHORT_HEADER    = 32'd17;
	localparam logic [7:0]  BER_LONG        = 8'h80;
	localparam logic [6:0]  BER_COUNT_MASK  = 7'h7F;

	// One result per frame or per error
	typedef struct packed {
		logic        has;
		status_t     status;
		logic [31:0] size;
	} result_t;

	// Universal label prefix 06 0E 2B 34
	function automatic logic [7:0] ul_prefix(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = 8'h06;
			2'd1:    b = 8'h0E;
			2'd2:    b = 8'h2B;
			default: b = 8'h34;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/klv_fd_cfg_regs.sv -----
// APB-style configuration register for the KLV frame delineator.
// Holds max_frame_bytes. Depends on klv_fd_pkg.
`default_nettype none

module klv_fd_cfg_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic      [31:0] max_frame_bytes
);

	logic [31:0] max_frame_q;
	logic        wr_en;

	assign wr_en = psel && penable && pwrite && (paddr[2] == klv_fd_pkg::REG_MAX_FRAME);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= klv_fd_pkg::RESET_MAX_FRAME;
		end else if (wr_en) begin
			max_frame_q <= pwdata;
		end
	end

	always_comb begin
		case (paddr[2])
			klv_fd_pkg::REG_MAX_FRAME: prdata = max_frame_q;
			default:                   prdata = '0;
		endcase
	end

	assign max_frame_bytes = max_frame_q;

endmodule

`default_nettype wire

// ----- hdl/klv_fd_parser.sv -----
// Frame parse state and combinational next-state logic for one stream byte.
// Checks prefix, decodes the BER length, checks the size limit, counts value bytes.
// Depends on klv_fd_pkg.
`default_nettype none

module klv_fd_parser #(
	parameter int MAX_LENGTH_BYTES = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic [7:0]          byte_in,
	input  wire logic [31:0]         max_frame_bytes,
	output klv_fd_pkg::result_t      result
);

	localparam int ACC_W  = 8 * MAX_LENGTH_BYTES;
	localparam int CMP_W  = (ACC_W > 33) ? ACC_W : 33;
	localparam int LCNT_W = $clog2(MAX_LENGTH_BYTES + 1);

	klv_fd_pkg::phase_t phase_q, phase_d;
	logic [31:0]        pos_q, pos_d;
	logic [LCNT_W-1:0]  cnt_q, cnt_d;
	logic [ACC_W-1:0]   acc_q, acc_d;
	logic [31:0]        total_q, total_d;

	logic [31:0]        pos_inc;
	logic [31:0]        kpos;
	logic [ACC_W-1:0]   acc_shift;
	logic [CMP_W-1:0]   hdr_w, vlen_w, lim_w, room_w;
	logic               over;
	logic [31:0]        total_w;
	logic [6:0]         n_long;
	logic               hdr_done;
	logic               emit;
	klv_fd_pkg::status_t emit_status;
	logic [31:0]        emit_size;

	assign pos_inc   = pos_q + 32'd1;
	assign kpos      = (phase_q == klv_fd_pkg::PH_KEY) ? pos_q : 32'd0;
	assign acc_shift = (acc_q << 8) | ACC_W'(byte_in);
	assign n_long    = byte_in[6:0] & klv_fd_pkg::BER_COUNT_MASK;

	// Shared limit check: header size and value length of whichever form ends the header
	assign hdr_w   = (phase_q == klv_fd_pkg::PH_LEN) ? CMP_W'(pos_inc)
	                                                 : CMP_W'(klv_fd_pkg::SHORT_HEADER);
	assign vlen_w  = (phase_q == klv_fd_pkg::PH_LEN) ? CMP_W'(acc_shift) : CMP_W'(byte_in);
	assign lim_w   = CMP_W'(max_frame_bytes);
	assign room_w  = lim_w - hdr_w;
	assign over    = (hdr_w > lim_w) || (vlen_w > room_w);
	assign total_w = 32'(hdr_w + vlen_w);

	always_comb begin
		phase_d     = phase_q;
		pos_d       = pos_inc;
		cnt_d       = cnt_q;
		acc_d       = acc_q;
		total_d     = total_q;
		hdr_done    = 1'b0;
		emit        = 1'b0;
		emit_status = klv_fd_pkg::ST_OK;
		emit_size   = '0;

		case (phase_q)
			klv_fd_pkg::PH_LEN: begin
				acc_d = acc_shift;
				if (cnt_q != '0) begin
					cnt_d = cnt_q - LCNT_W'(1);
				end
				if (cnt_q <= LCNT_W'(1)) begin
					hdr_done = 1'b1;
				end
			end
			klv_fd_pkg::PH_VALUE: begin
				if (pos_inc >= total_q) begin
					emit      = 1'b1;
					emit_size = total_q;
				end
			end
			default: begin
				// Key phase; any other code restarts the frame here
				pos_d = kpos + 32'd1;
				if (kpos < klv_fd_pkg::UL_PREFIX_LEN) begin
					if (byte_in != klv_fd_pkg::ul_prefix(kpos[1:0])) begin
						emit        = 1'b1;
						emit_status = klv_fd_pkg::ST_BAD_FORM;
					end
				end else if (kpos >= klv_fd_pkg::KEY_BYTES) begin
					if ((byte_in & klv_fd_pkg::BER_LONG) == 8'h00) begin
						hdr_done = 1'b1;
					end else if ((n_long == 7'd0) || (n_long > 7'(MAX_LENGTH_BYTES))) begin
						emit        = 1'b1;
						emit_status = klv_fd_pkg::ST_BAD_FORM;
					end else begin
						cnt_d   = LCNT_W'(n_long);
						acc_d   = '0;
						phase_d = klv_fd_pkg::PH_LEN;
					end
				end
			end
		endcase

		if (hdr_done) begin
			if (over) begin
				emit        = 1'b1;
				emit_status = klv_fd_pkg::ST_OVER_LIMIT;
			end else if (vlen_w == '0) begin
				emit      = 1'b1;
				emit_size = total_w;
			end else begin
				total_d = total_w;
				phase_d = klv_fd_pkg::PH_VALUE;
			end
		end

		if (emit) begin
			phase_d = klv_fd_pkg::PH_KEY;
			pos_d   = '0;
			cnt_d   = '0;
			acc_d   = '0;
			total_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= klv_fd_pkg::PH_KEY;
			pos_q   <= '0;
			cnt_q   <= '0;
			acc_q   <= '0;
			total_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			cnt_q   <= cnt_d;
			acc_q   <= acc_d;
			total_q <= total_d;
		end
	end

	assign result = {emit, emit_status, emit_size};

endmodule

`default_nettype wire

// ----- hdl/klv_frame_delineator.sv -----
// KLV frame delineator top level: input byte register, parser, result register.
// Depends on klv_fd_pkg, klv_fd_cfg_regs and klv_fd_parser.
//
// Usage:
//   s_axis carries the KLV byte stream, one byte per request in tdata[7:0].
//   m_axis carries one request per frame or per error: tuser holds the status
//   (0 frame complete, 1 bad prefix or bad BER length form, 2 frame over the
//   size limit), tdata the total frame size in bytes (0 unless status is 0).
//   A result leaves on the last byte of a frame, on the byte that breaks the
//   prefix or length form, or on the last header byte when the size is over
//   the limit; the next byte then starts a new frame.
//   The APB port holds max_frame_bytes at address 0 (reset 0xFFFFFFFF);
//   write it only while the stream is idle.
// Timing:
//   One byte per cycle sustained unless a result waits on a stalled m_axis.
//   A byte waits in the input register while the parser works out its next
//   state from it; any result it gives is loaded into the result register,
//   which drives m_axis. The parse state loop holds the prefix compare, the
//   shift-in of the length and one 64-bit limit compare.
// Reset and stalls:
//   Reset clears both valid flags and returns the parser to the prefix phase.
//   When m_axis stalls, the result register holds; bytes that give no result
//   keep flowing, and a byte that gives a result waits in the input register,
//   which drops s_axis_tready until the result register frees up.
`default_nettype none

module klv_frame_delineator #(
	parameter int MAX_LENGTH_BYTES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// stream in
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	// stream out
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [31:0] m_axis_tdata,   // [31:0] frame_size
	output logic      [1:0]  m_axis_tuser,   // [1:0] status
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	logic [31:0]         max_frame_bytes;
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                go;
	logic                out_free;
	klv_fd_pkg::result_t res;
	logic                out_valid_s2;
	klv_fd_pkg::status_t out_status_s2;
	logic [31:0]         out_size_s2;

	assign pready = 1'b1;

	klv_fd_cfg_regs u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.max_frame_bytes (max_frame_bytes)
	);

	klv_fd_parser #(
		.MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
	) u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (go),
		.byte_in         (byte_s1),
		.max_frame_bytes (max_frame_bytes),
		.result          (res)
	);

	// Advance the held byte unless it makes a result the output cannot take
	assign out_free      = !out_valid_s2 || m_axis_tready;
	assign go            = valid_s1 && (!res.has || out_free);
	assign s_axis_tready = !valid_s1 || go;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Result register: load a new result, else drop the old one once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (go && res.has) begin
			out_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res.has) begin
			out_status_s2 <= res.status;
			out_size_s2   <= res.size;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = out_size_s2;
	assign m_axis_tuser  = out_status_s2;

	// A completed frame has at least a full header; an error carries no size
	a_size_vs_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> ((out_status_s2 == klv_fd_pkg::ST_OK) ?
			(out_size_s2 >= klv_fd_pkg::SHORT_HEADER) : (out_size_s2 == 32'd0)))
		else $error("result size does not match status");

	// A byte held back in the input register stays put
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !go) |=> (valid_s1 && $stable(byte_s1)))
		else $error("stalled input byte changed or vanished");

	// A result produced by the parser always lands in the result register
	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(go && res.has) |=> out_valid_s2)
		else $error("parser result lost");

	// The parser never steps on a result while the output is blocked
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && !m_axis_tready && res.has) |-> !go)
		else $error("result overwrote a pending output");

endmodule

`default_nettype wire

// ----- bench/tb_klv_frame_delineator.sv -----
// Self-checking bench for klv_frame_delineator: byte stream in, frame results out.
// Depends on klv_fd_pkg and the RTL under hdl/; nothing else is read or needed.
module tb_klv_frame_delineator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LEN      = 8;
	localparam int DRAIN_CYCLES = 6;
	localparam int QUIET_LIMIT  = 2000;  // cycles with no request moving at all
	localparam int IDLE_PCT     = 27;

	// Register addresses: byte address 4*index on a 3-bit paddr
	localparam logic [2:0] ADDR_MAX_FRAME = {klv_fd_pkg::REG_MAX_FRAME, 2'b00};
	localparam logic [2:0] ADDR_SPARE     = 3'd4;   // no register here

	localparam logic [7:0] UL_LABEL [0:3] = '{8'h06, 8'h0E, 8'h2B, 8'h34};

	typedef enum int {
		SEQ_GOOD,
		SEQ_OVER,
		SEQ_BAD_PREFIX,
		SEQ_BAD_COUNT,
		SEQ_NOISE
	} seq_kind_t;

	typedef struct {
		klv_fd_pkg::status_t status;
		logic [31:0]         size;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;      // [7:0] data_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;           // [31:0] frame_size
	logic [1:0]  m_tuser;           // [1:0] status

	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Stimulus and scoreboard
	logic [7:0]    byte_q [$];
	frame_result_t frame_results_q [$];
	logic          idle_on = 1'b1;
	int            fail_count = 0;
	int            bytes_taken = 0;
	int            results_seen = 0;
	int            cfg_writes = 0;
	int            bytes_queued = 0;
	int            seqs_queued = 0;
	int            quiet_cycles = 0;

	// Predictor copy of the block: register and parse state
	logic [31:0]         max_frame_cfg = klv_fd_pkg::RESET_MAX_FRAME;
	logic [31:0]         ber_pos;
	logic [3:0]          len_bytes_left;
	logic [63:0]         len_accum;
	logic [31:0]         frame_bytes_total;
	klv_fd_pkg::phase_t  parse_ph;

	klv_frame_delineator #(
		.MAX_LENGTH_BYTES(MAX_LEN)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata (s_tdata),
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata (m_tdata),
		.m_axis_tuser (m_tuser),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Frame predictor
	// ------------------------------------------------------------------

	// Clear parse state so the next byte opens a frame.
	task automatic start_frame();
		ber_pos           = '0;
		len_bytes_left    = '0;
		len_accum         = '0;
		frame_bytes_total = '0;
		parse_ph          = klv_fd_pkg::PH_KEY;
	endtask

	task automatic post_result(input klv_fd_pkg::status_t st, input logic [31:0] size);
		frame_result_t r;
		r.status = st;
		r.size   = size;
		frame_results_q.insert(frame_results_q.size(), r);
		start_frame();
	endtask

	// Header complete: check the limit in 64 bits, then finish or await the value.
	task automatic close_header(input logic [31:0] hdr, input logic [63:0] vlen);
		logic [63:0] lim;
		lim = {32'd0, max_frame_cfg};
		if ({32'd0, hdr} > lim || vlen > lim - {32'd0, hdr}) begin
			post_result(klv_fd_pkg::ST_OVER_LIMIT, '0);
		end else if (vlen == 64'd0) begin
			post_result(klv_fd_pkg::ST_OK, hdr);
		end else begin
			frame_bytes_total = 32'({32'd0, hdr} + vlen);
			parse_ph          = klv_fd_pkg::PH_VALUE;
		end
	endtask

	task automatic predict_byte(input logic [7:0] b);
		logic [31:0] pos;
		logic [6:0]  n;
		pos     = ber_pos;
		ber_pos = pos + 32'd1;
		case (parse_ph)
			klv_fd_pkg::PH_LEN: begin
				len_accum = {len_accum[55:0], b};
				if (len_bytes_left != 0)
					len_bytes_left = len_bytes_left - 4'd1;
				if (len_bytes_left == 0)
					close_header(pos + 32'd1, len_accum);
			end
			klv_fd_pkg::PH_VALUE: begin
				if (ber_pos >= frame_bytes_total)
					post_result(klv_fd_pkg::ST_OK, frame_bytes_total);
			end
			default: begin
				if (pos < klv_fd_pkg::UL_PREFIX_LEN) begin
					// prefix mismatch fails on the first differing byte
					if (b != UL_LABEL[pos[1:0]])
						post_result(klv_fd_pkg::ST_BAD_FORM, '0);
				end else if (pos < klv_fd_pkg::KEY_BYTES) begin
					// rest of the key passes unchecked
				end else if (b < klv_fd_pkg::BER_LONG) begin
					close_header(klv_fd_pkg::SHORT_HEADER, {56'd0, b});
				end else begin
					n = b[6:0] & klv_fd_pkg::BER_COUNT_MASK;
					if (n == 0 || int'(n) > MAX_LEN) begin
						post_result(klv_fd_pkg::ST_BAD_FORM, '0);
					end else begin
						len_bytes_left = n[3:0];
						len_accum      = '0;
						parse_ph       = klv_fd_pkg::PH_LEN;
					end
				end
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Byte driver: hold each request until taken, idle at random
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			start_frame();
		end else begin
			if (s_tvalid && s_tready) begin
				predict_byte(s_tdata);
				bytes_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (byte_q.size() != 0 && !(idle_on && $urandom_range(0, 99) < IDLE_PCT)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= byte_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: compare each taken result with the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		frame_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (frame_results_q.size() == 0) begin
					$error("unexpected result: status %0d frame_size %0d", m_tuser, m_tdata);
					fail_count++;
				end else begin
					want = frame_results_q.pop_front();
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser);
						fail_count++;
					end
					if (m_tdata !== want.size) begin
						$error("frame_size: expected %0d, got %0d", want.size, m_tdata);
						fail_count++;
					end
				end
			end
			m_tready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Watchdog: end the run when no request has moved for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
			$display("tb_klv_frame_delineator NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------

	// Append one byte to the stimulus queue.
	task automatic queue_byte(input logic [7:0] b);
		byte_q.insert(byte_q.size(), b);
		bytes_queued++;
	endtask

	// Push bytes [from, upto) of a header key: prefix first, then random key bytes.
	task automatic push_key(input int from, input int upto);
		for (int i = from; i < upto; i++)
			queue_byte(i < 4 ? UL_LABEL[i] : 8'($urandom));
	endtask

	// Push the BER length: short form when nlen is 0, else 0x80|nlen and big-endian bytes.
	task automatic push_len(input int nlen, input logic [63:0] vlen);
		if (nlen == 0) begin
			queue_byte(vlen[7:0]);
		end else begin
			queue_byte(klv_fd_pkg::BER_LONG | 8'(nlen));
			for (int i = nlen - 1; i >= 0; i--)
				queue_byte(vlen[8*i +: 8]);
		end
	endtask

	task automatic push_value(input int count);
		repeat (count) queue_byte(8'($urandom));
	endtask

	// Build one sequence against the current limit; drop the value bytes when it
	// will fail, since the block starts a new frame right after the header.
	task automatic push_seq(input seq_kind_t kind);
		int          pos;
		int          nlen;
		int          hdr;
		logic [63:0] lim;
		logic [63:0] room;
		logic [63:0] vlen;
		logic        over;
		lim = {32'd0, max_frame_cfg};
		seqs_queued++;
		case (kind)
			SEQ_NOISE: begin
				repeat ($urandom_range(1, 3))
					queue_byte(8'($urandom));
			end
			SEQ_BAD_PREFIX: begin
				pos = $urandom_range(0, 3);
				push_key(0, pos);
				queue_byte(UL_LABEL[pos] ^ 8'($urandom_range(1, 255)));
			end
			SEQ_BAD_COUNT: begin
				push_key(0, 16);
				queue_byte($urandom_range(0, 1) ? klv_fd_pkg::BER_LONG
				                                : 8'($urandom_range(8'h89, 8'hFF)));
			end
			default: begin
				push_key(0, 16);
				nlen = $urandom_range(0, 1) ? 0 : $urandom_range(1, MAX_LEN);
				hdr  = 17 + nlen;
				room = (lim >= 64'(hdr)) ? lim - 64'(hdr) : 64'd0;
				if (kind == SEQ_OVER) begin
					vlen = room + 64'd1 + 64'($urandom_range(0, 3));
					if ($urandom_range(0, 3) == 0) begin
						// reach the top bytes of the length accumulator
						nlen = MAX_LEN;
						vlen = {32'($urandom), 32'($urandom)} | (64'd1 << 32);
					end
				end else if (room <= 64'd60 && $urandom_range(0, 5) == 0) begin
					vlen = room;   // exact fit against the limit
				end else begin
					vlen = 64'($urandom_range(0, 12));
					if (vlen > room)
						vlen = room;
				end
				// widen to eight length bytes when the value does not encode
				if ((nlen == 0 && vlen > 64'd127) || (nlen != 0 && nlen < 8 && (vlen >> (8 * nlen)) != 0))
					nlen = MAX_LEN;
				hdr  = 17 + nlen;
				over = (64'(hdr) > lim) || (vlen > lim - 64'(hdr));
				push_len(nlen, vlen);
				if (!over)
					push_value(int'(vlen));
			end
		endcase
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr[2] == klv_fd_pkg::REG_MAX_FRAME)
			max_frame_cfg = data;
		cfg_writes++;
	endtask

	// Hold until every byte is taken and every predicted result has come back.
	task automatic wait_idle();
		do @(posedge clk);
		while (byte_q.size() != 0 || s_tvalid || frame_results_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [31:0] phase_limit [0:5];
		int          r;
		int          start_bytes;
		int          start_seqs;
		phase_limit = '{32'd17, 32'd5, 32'd30, 32'd0, 32'd2000, 32'hFFFF_FFFF};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part under the reset limit
		push_key(0, 16); push_len(0, 64'd0);                   // zero length, short form
		for (int i = 0; i < 4; i++) begin                      // mismatch on each prefix byte
			push_key(0, i);
			queue_byte(UL_LABEL[i] ^ 8'hFF);
		end
		push_key(0, 16); queue_byte(klv_fd_pkg::BER_LONG);     // long form, count zero
		push_key(0, 16); queue_byte(8'h89);                    // count one above the max
		push_key(0, 16); push_len(1, 64'd3); push_value(3);
		push_key(0, 16); push_len(8, 64'd0);                   // zero length, long form
		push_key(0, 16); push_len(8, '1);                      // over limit, all ones
		push_key(0, 16); push_len(4, 64'hFFFF_FFFF);           // over limit at 32 bits
		push_key(0, 16); push_len(2, 64'd5); push_value(5);
		wait_idle();

		// Lower the limit in the middle of a key; the new value rules the check
		push_key(0, 10);
		wait_idle();
		apb_write(ADDR_MAX_FRAME, 32'd20);
		push_key(10, 16); push_len(0, 64'd10);                 // 27 bytes, over 20
		push_key(0, 16); push_len(0, 64'd3); push_value(3);    // exactly 20 bytes
		push_key(0, 16); push_len(0, 64'd127);                 // largest short form, over 20
		wait_idle();

		// Random phases, one limit setting each
		for (int p = 0; p < 6; p++) begin
			if (p == 2)
				apb_write(ADDR_SPARE, $urandom);               // unmapped, must not land
			apb_write(ADDR_MAX_FRAME, p == 3 ? 32'($urandom_range(17, 120)) : phase_limit[p]);
			idle_on <= (p != 4);                               // one long stretch at full rate
			start_bytes = bytes_queued;
			start_seqs  = seqs_queued;
			while (bytes_queued - start_bytes < (p == 4 ? 60 : 16) ||
			       seqs_queued - start_seqs < 2) begin
				r = $urandom_range(0, 99);
				if (r < 55)
					push_seq(SEQ_GOOD);
				else if (r < 67)
					push_seq(SEQ_OVER);
				else if (r < 77)
					push_seq(SEQ_BAD_PREFIX);
				else if (r < 85)
					push_seq(SEQ_BAD_COUNT);
				else
					push_seq(SEQ_NOISE);
			end
			wait_idle();
		end

		$display("run covered %0d stream bytes, %0d checked results, %0d register writes",
			bytes_taken, results_seen, cfg_writes);
		$display("limits from 5 to 0xFFFFFFFF, bad prefix and length forms, over-limit frames");
		if (fail_count == 0)
			$display("tb_klv_frame_delineator OK");
		else
			$display("tb_klv_frame_delineator NOT OK");
		$finish;
	end

endmodule
